@@ rtl/ctmf_pkg.sv @@
// ctmf_pkg: shared constants, codes and the job descriptor of the ctaphid fragmenter
// used by the front, queue, back and top modules; depends on nothing
package ctmf_pkg;

	// packet geometry
	localparam int PACKET_BYTES = 64;
	localparam int INIT_HDR     = 7;
	localparam int CONT_HDR     = 5;
	localparam int INIT_DATA    = PACKET_BYTES - INIT_HDR;
	localparam int MAX_LEN      = 7609;

	// field widths
	localparam int LEN_W  = 13;
	localparam int POS_W  = $clog2(PACKET_BYTES + 1);
	localparam int BPOS_W = $clog2(PACKET_BYTES);
	localparam int SEQ_W  = 7;
	localparam int IDX_W  = 3;

	// header byte indexes
	localparam logic [IDX_W-1:0] HDR_LAST_INIT = IDX_W'(INIT_HDR - 1);
	localparam logic [IDX_W-1:0] HDR_LAST_CONT = IDX_W'(CONT_HDR - 1);
	localparam logic [BPOS_W-1:0] POS_LAST     = BPOS_W'(PACKET_BYTES - 1);

	// job queue depth
	localparam int QUEUE_DEPTH = 2;

	// request codes on the command field
	typedef enum logic {
		CMD_START = 1'b0,
		CMD_DATA  = 1'b1
	} cmd_t;

	// back end sequencer phases
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HDR,
		PH_DATA,
		PH_PAD
	} phase_t;

	// one unit of work for the back end
	typedef struct packed {
		logic                is_start;
		logic [31:0]         channel;
		logic [7:0]          value;
		logic [LEN_W-1:0]    length;
		logic [SEQ_W-1:0]    seq;
		logic                cont_hdr;
		logic                pad;
		logic [BPOS_W-1:0]   start_pos;
	} job_t;

endpackage

@@ rtl/ctmf_front.sv @@
// ctmf_front: accepts requests, tracks message state and turns each start request
// and each in-length payload byte of an open message into a job; depends on ctmf_pkg
module ctmf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic [31:0]        channel_id,
	input  logic [7:0]         message_command,
	input  logic [12:0]        message_length,
	input  logic               single_packet,
	input  logic [7:0]         data_byte,
	input  logic               full,
	output logic               push,
	output ctmf_pkg::job_t     job
);
	import ctmf_pkg::*;

	logic              active_q;
	logic [LEN_W-1:0]  limit_q;
	logic [LEN_W-1:0]  taken_q;
	logic [POS_W-1:0]  pos_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [31:0]       channel_q;

	logic              acc;
	logic              is_start;
	logic [LEN_W-1:0]  len_sat;
	logic [LEN_W-1:0]  start_limit;
	logic [LEN_W-1:0]  taken_inc;
	logic              take_ok;
	logic              need_hdr;
	logic              data_final;
	logic [POS_W-1:0]  pos_base;
	logic [POS_W-1:0]  pos_after;

	assign in_ready = !full;
	assign acc      = in_valid && in_ready;
	assign is_start = (command == CMD_START);

	// classify the request
	always_comb begin
		len_sat     = (message_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : message_length;
		start_limit = (single_packet && (len_sat > LEN_W'(INIT_DATA))) ?
		              LEN_W'(INIT_DATA) : len_sat;
		taken_inc   = taken_q + LEN_W'(1);
		take_ok     = active_q && (taken_q < limit_q);
		need_hdr    = (pos_q == POS_W'(PACKET_BYTES));
		data_final  = (taken_inc >= limit_q);
		pos_base    = need_hdr ? POS_W'(CONT_HDR) : pos_q;
		pos_after   = pos_base + POS_W'(1);
	end

	// job descriptor
	always_comb begin
		job.is_start  = is_start;
		job.channel   = is_start ? channel_id : channel_q;
		job.value     = is_start ? message_command : data_byte;
		job.length    = len_sat;
		job.seq       = seq_q;
		job.cont_hdr  = !is_start && need_hdr;
		job.pad       = is_start ? (start_limit == '0) : data_final;
		job.start_pos = (is_start || need_hdr) ? '0 : pos_q[BPOS_W-1:0];
	end

	assign push = acc && (is_start || take_ok);

	// message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			limit_q  <= '0;
			taken_q  <= '0;
			pos_q    <= '0;
			seq_q    <= '0;
		end else if (acc) begin
			if (is_start) begin
				limit_q  <= start_limit;
				taken_q  <= '0;
				seq_q    <= '0;
				active_q <= (start_limit != '0);
				pos_q    <= (start_limit == '0) ? POS_W'(PACKET_BYTES) : POS_W'(INIT_HDR);
			end else if (take_ok) begin
				taken_q <= taken_inc;
				if (need_hdr) begin
					seq_q <= seq_q + SEQ_W'(1);
				end
				if (data_final) begin
					active_q <= 1'b0;
					pos_q    <= POS_W'(PACKET_BYTES);
				end else begin
					pos_q <= pos_after;
				end
			end
		end
	end

	// held channel for continuation headers
	always_ff @(posedge clk) begin
		if (acc && is_start) begin
			channel_q <= channel_id;
		end
	end

endmodule

@@ rtl/ctmf_queue.sv @@
// ctmf_queue: short job queue between the front and the back end
// depends on ctmf_pkg
module ctmf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ctmf_pkg::job_t job_in,
	input  logic           pop,
	output ctmf_pkg::job_t job_out,
	output logic           full,
	output logic           empty
);
	import ctmf_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign job_out = slots_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= job_in;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/ctmf_back.sv @@
// ctmf_back: byte sequencer that plays out queued jobs into the packet stream
// depends on ctmf_pkg
module ctmf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  ctmf_pkg::job_t head,
	input  logic           empty,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     packet_byte,
	output logic           packet_end,
	output logic           message_end,
	output logic           run_last
);
	import ctmf_pkg::*;

	phase_t             state_q;
	logic [IDX_W-1:0]   idx_q;
	logic [BPOS_W-1:0]  pos_q;

	logic               out_valid_q;
	logic [7:0]         byte_q;
	logic               pend_q;
	logic               mend_q;
	logic               rlast_q;

	phase_t             cur_phase;
	logic [IDX_W-1:0]   cur_idx;
	logic [BPOS_W-1:0]  cur_pos;
	phase_t             nxt_phase;
	logic               done;
	logic               work;
	logic               adv;
	logic [7:0]         cur_byte;
	logic               msg_last;
	logic               cur_pend;

	// where the current byte stands, a fresh job starts from the queue head
	always_comb begin
		if (state_q == PH_IDLE) begin
			cur_phase = (head.is_start || head.cont_hdr) ? PH_HDR : PH_DATA;
			cur_idx   = '0;
			cur_pos   = head.start_pos;
		end else begin
			cur_phase = state_q;
			cur_idx   = idx_q;
			cur_pos   = pos_q;
		end
	end

	assign work     = (state_q != PH_IDLE) || !empty;
	assign adv      = work && (!out_valid_q || out_ready);
	assign pop      = adv && done;
	assign cur_pend = (cur_pos == POS_LAST);

	// next state
	always_comb begin
		nxt_phase = PH_IDLE;
		done      = 1'b0;
		unique case (cur_phase)
			PH_HDR: begin
				if (head.is_start) begin
					if (cur_idx == HDR_LAST_INIT) begin
						nxt_phase = head.pad ? PH_PAD : PH_IDLE;
						done      = !head.pad;
					end else begin
						nxt_phase = PH_HDR;
					end
				end else begin
					nxt_phase = (cur_idx == HDR_LAST_CONT) ? PH_DATA : PH_HDR;
				end
			end
			PH_DATA: begin
				if (head.pad && !cur_pend) begin
					nxt_phase = PH_PAD;
				end else begin
					done = 1'b1;
				end
			end
			PH_PAD: begin
				if (cur_pend) begin
					done = 1'b1;
				end else begin
					nxt_phase = PH_PAD;
				end
			end
			PH_IDLE: begin
				nxt_phase = PH_IDLE;
			end
		endcase
	end

	// byte selection
	always_comb begin
		cur_byte = 8'h00;
		msg_last = 1'b0;
		unique case (cur_phase)
			PH_HDR: begin
				unique case (cur_idx)
					3'd0:    cur_byte = head.channel[31:24];
					3'd1:    cur_byte = head.channel[23:16];
					3'd2:    cur_byte = head.channel[15:8];
					3'd3:    cur_byte = head.channel[7:0];
					3'd4:    cur_byte = head.is_start ? head.value : {1'b0, head.seq};
					3'd5:    cur_byte = {3'b000, head.length[12:8]};
					3'd6:    cur_byte = head.length[7:0];
					default: cur_byte = 8'h00;
				endcase
			end
			PH_DATA: begin
				cur_byte = head.value;
				msg_last = head.pad;
			end
			PH_PAD: begin
				msg_last = 1'b1;
			end
			PH_IDLE: begin
				cur_byte = 8'h00;
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_IDLE;
			idx_q   <= '0;
			pos_q   <= '0;
		end else if (adv) begin
			state_q <= nxt_phase;
			idx_q   <= cur_idx + IDX_W'(1);
			pos_q   <= cur_pos + BPOS_W'(1);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q  <= cur_byte;
			pend_q  <= cur_pend;
			mend_q  <= cur_pend && msg_last;
			rlast_q <= done;
		end
	end

	assign out_valid   = out_valid_q;
	assign packet_byte = byte_q;
	assign packet_end  = pend_q;
	assign message_end = mend_q;
	assign run_last    = rlast_q;

endmodule

@@ rtl/ctaphid_message_fragmenter.sv @@
// ctaphid_message_fragmenter: top level of the ctaphid message fragmenter
// depends on ctmf_pkg, ctmf_front, ctmf_queue and ctmf_back
//
// A start request opens a message and yields the 7-byte init header (channel id
// big-endian, command, 13-bit length as two bytes); each payload byte request yields
// that byte, preceded by a 5-byte continuation header (channel id, sequence from 0)
// when it opens a new packet, and the last payload byte is followed by zero padding
// up to 64 bytes. The front takes one request per cycle while its two-entry job queue
// has room; the back sequencer emits one stream byte per cycle unless stalled, so a
// plain payload byte yields one byte, a byte that opens a continuation packet six, a
// start request seven; an empty start adds 57 padding bytes and a closing byte up to
// 58. Payload requests with no open message, or beyond the length, are taken and
// produce nothing. A start while a message is open abandons it mid-packet.
module ctaphid_message_fragmenter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [31:0] channel_id,
	input  logic [7:0]  message_command,
	input  logic [12:0] message_length,
	input  logic        single_packet,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  packet_byte,
	output logic        packet_end,
	output logic        message_end,
	output logic        run_last
);
	import ctmf_pkg::*;

	job_t job_in;
	job_t job_head;
	logic push;
	logic pop;
	logic full;
	logic empty;

	// request intake and classification
	ctmf_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.channel_id      (channel_id),
		.message_command (message_command),
		.message_length  (message_length),
		.single_packet   (single_packet),
		.data_byte       (data_byte),
		.full            (full),
		.push            (push),
		.job             (job_in)
	);

	// job queue
	ctmf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (job_in),
		.pop     (pop),
		.job_out (job_head),
		.full    (full),
		.empty   (empty)
	);

	// byte stream sequencer
	ctmf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (job_head),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.packet_byte (packet_byte),
		.packet_end  (packet_end),
		.message_end (message_end),
		.run_last    (run_last)
	);

endmodule

@@ rtl/ctmf_checker.sv @@
// ctmf_checker: port level checks on the packet stream of the fragmenter
// depends on ctaphid_message_fragmenter, to which it is bound below
module ctmf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] packet_byte,
	input logic       packet_end,
	input logic       message_end,
	input logic       run_last
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its fields
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(packet_byte) && $stable(packet_end)
		&& $stable(message_end) && $stable(run_last))
		else $error("result changed while stalled");

	// a message only closes on a full packet
	a_mend_pend: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_end |-> packet_end)
		else $error("message end off a packet boundary");

	// the closing byte is the last one a request causes
	a_mend_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_end |-> run_last)
		else $error("message end not on the last result of a request");

endmodule

bind ctaphid_message_fragmenter ctmf_checker u_ctmf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.packet_byte (packet_byte),
	.packet_end  (packet_end),
	.message_end (message_end),
	.run_last    (run_last)
);

@@ tb/ctaphid_message_fragmenter_tb.sv @@
// ctaphid_message_fragmenter_tb: self-checking bench for the ctaphid message fragmenter
// a class predicts the 64-byte packet stream per request; tasks drive the request side
// depends on ctmf_pkg and the ctaphid_message_fragmenter rtl
`timescale 1ns / 1ps

module ctaphid_message_fragmenter_tb;
	import ctmf_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 150;
	localparam int RANDOM_REQS  = 180;

	// one predicted byte of the outgoing stream
	typedef struct {
		logic [7:0] value;
		logic       pkt_end;
		logic       msg_end;
		logic       run_end;
	} stream_byte_t;

	// predicts the packet stream and keeps the bytes still to come
	class ctaphid_stream_model;
		bit                active;
		logic [31:0]       chan;
		logic [LEN_W-1:0]  msg_len;
		logic [LEN_W-1:0]  taken;
		logic [POS_W-1:0]  pos;
		logic [SEQ_W-1:0]  seq;
		bit                truncate;
		stream_byte_t      expected_bytes[$];
		int                mismatches;
		int                bytes_checked;
		int                packets_checked;

		function new();
			active = 0;
			chan = '0;
			msg_len = '0;
			taken = '0;
			pos = '0;
			seq = '0;
			truncate = 0;
			mismatches = 0;
			bytes_checked = 0;
			packets_checked = 0;
		endfunction

		function void emit(logic [7:0] b, bit msg_last);
			stream_byte_t e;
			pos = pos + 1'b1;
			e.value = b;
			e.pkt_end = (pos >= POS_W'(PACKET_BYTES));
			e.msg_end = e.pkt_end && msg_last;
			e.run_end = 1'b0;
			expected_bytes.push_back(e);
		endfunction

		function void emit_channel();
			emit(chan[31:24], 1'b0);
			emit(chan[23:16], 1'b0);
			emit(chan[15:8], 1'b0);
			emit(chan[7:0], 1'b0);
		endfunction

		// zero fill to the packet boundary, then the message is closed
		function void pad_out();
			while (pos < POS_W'(PACKET_BYTES))
				emit(8'h00, 1'b1);
			active = 0;
		endfunction

		function logic [LEN_W-1:0] take_limit();
			if (truncate && msg_len > LEN_W'(INIT_DATA))
				return LEN_W'(INIT_DATA);
			return msg_len;
		endfunction

		// predict the bytes caused by one accepted request, returns their count
		function int take_request(cmd_t c, logic [31:0] ch, logic [7:0] mc,
				logic [LEN_W-1:0] len_in, logic sp, logic [7:0] db);
			int first;
			logic [LEN_W-1:0] len;
			logic [LEN_W-1:0] lim;
			bit last_byte;
			first = expected_bytes.size();
			if (c == CMD_START) begin
				// lengths beyond the sequence range saturate
				len = (len_in > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len_in;
				chan = ch;
				msg_len = len;
				truncate = sp;
				taken = '0;
				seq = '0;
				pos = '0;
				active = 1;
				emit_channel();
				emit(mc, 1'b0);
				emit(8'(len >> 8), 1'b0);
				emit(len[7:0], 1'b0);
				if (take_limit() == '0)
					pad_out();
			end else begin
				lim = take_limit();
				if (!active || taken >= lim)
					return 0;
				// continuation header goes out with the first byte of the packet
				if (pos >= POS_W'(PACKET_BYTES)) begin
					pos = '0;
					emit_channel();
					emit({1'b0, seq}, 1'b0);
					seq = seq + 1'b1;
				end
				taken = taken + 1'b1;
				last_byte = (taken >= lim);
				emit(db, last_byte);
				if (last_byte)
					pad_out();
			end
			if (expected_bytes.size() > first)
				expected_bytes[expected_bytes.size() - 1].run_end = 1'b1;
			return expected_bytes.size() - first;
		endfunction

		function void report(string what, logic [7:0] exp_v, logic [7:0] act_v);
			mismatches++;
			$display("%0t: %s expected %0h actual %0h", $time, what, exp_v, act_v);
		endfunction

		// compare one accepted stream byte with the oldest prediction
		function void check_byte(logic [7:0] b, logic pe, logic me, logic rl);
			stream_byte_t e;
			if (expected_bytes.size() == 0) begin
				mismatches++;
				$display("%0t: byte %02h pe %0b me %0b rl %0b expected none actual this",
					$time, b, pe, me, rl);
				return;
			end
			e = expected_bytes.pop_front();
			bytes_checked++;
			if (pe === 1'b1)
				packets_checked++;
			if (b !== e.value)
				report("packet_byte", e.value, b);
			if (pe !== e.pkt_end)
				report("packet_end", 8'(e.pkt_end), 8'(pe));
			if (me !== e.msg_end)
				report("message_end", 8'(e.msg_end), 8'(me));
			if (rl !== e.run_end)
				report("run_last", 8'(e.run_end), 8'(rl));
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [31:0] channel_id;
	logic [7:0]  message_command;
	logic [12:0] message_length;
	logic        single_packet;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  packet_byte;
	logic        packet_end;
	logic        message_end;
	logic        run_last;

	ctaphid_stream_model stream;
	bit idle_on;
	bit held_off;
	int hold_left;
	int burst_left;
	int reqs_taken;
	int starts_taken;
	int useful_reqs;
	int cycle_count;

	ctaphid_message_fragmenter i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.channel_id      (channel_id),
		.message_command (message_command),
		.message_length  (message_length),
		.single_packet   (single_packet),
		.data_byte       (data_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.packet_byte     (packet_byte),
		.packet_end      (packet_end),
		.message_end     (message_end),
		.run_last        (run_last)
	);

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// note accepted requests, then check accepted stream bytes, in one place
	always @(posedge clk) begin : monitor
		int n;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				n = stream.take_request(cmd_t'(command), channel_id, message_command,
					message_length, single_packet, data_byte);
				reqs_taken++;
				if (cmd_t'(command) == CMD_START)
					starts_taken++;
				if (n > 0)
					useful_reqs++;
			end
			if (out_valid && out_ready)
				stream.check_byte(packet_byte, packet_end, message_end, run_last);
		end
	end

	// receiver: random stall bursts and one long hold-off
	initial begin
		out_ready = 1'b0;
		hold_left = 0;
		burst_left = 0;
		held_off = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && reqs_taken >= 60) begin
				held_off = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (burst_left > 0) begin
				burst_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				burst_left = $urandom_range(1, 7) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// offer one request and wait for it to be taken; entered and left at a falling edge
	task automatic offer_request(cmd_t c, logic [31:0] ch, logic [7:0] mc,
			logic [12:0] len, logic sp, logic [7:0] db);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command <= c;
		channel_id <= ch;
		message_command <= mc;
		message_length <= len;
		single_packet <= sp;
		data_byte <= db;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// start request; the payload byte field carries junk
	task automatic send_start(logic [31:0] ch, logic [7:0] mc, logic [12:0] len, logic sp);
		offer_request(CMD_START, ch, mc, len, sp, 8'($urandom));
	endtask

	// payload byte request; the header fields carry junk
	task automatic send_data(logic [7:0] db);
		offer_request(CMD_DATA, $urandom, 8'($urandom), 13'($urandom), 1'($urandom), db);
	endtask

	// a start, some payload bytes, then optional bytes past the end
	task automatic run_message(logic [12:0] len, logic sp, int nbytes, int extra);
		send_start($urandom, 8'($urandom), len, sp);
		repeat (nbytes) send_data(8'($urandom));
		repeat (extra) send_data(8'($urandom));
	endtask

	initial begin : stimulus
		int kind;
		int r;
		int eff;
		int nbytes;
		int goal;
		logic [12:0] len;
		logic sp;

		stream = new();
		idle_on = 1;
		reqs_taken = 0;
		starts_taken = 0;
		useful_reqs = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_START;
		channel_id = '0;
		message_command = '0;
		message_length = '0;
		single_packet = 1'b0;
		data_byte = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: data with no open message
		send_data(8'hFF);
		// empty message with all-ones header fields
		send_start(32'hFFFF_FFFF, 8'hFF, 13'd0, 1'b0);
		// oversized length saturates, single packet
		send_start(32'h0000_0000, 8'h00, 13'h1FFF, 1'b1);
		send_data(8'h00);
		// start while a message is open abandons it
		send_start(32'h1234_5678, 8'hA5, 13'd1, 1'b0);
		send_data(8'h3C);
		// beyond the length, ignored
		send_data(8'hAB);
		// short single packet message then a stray byte
		send_start(32'h89AB_CDEF, 8'h5A, 13'd3, 1'b1);
		send_data(8'h01);
		send_data(8'h80);
		send_data(8'h7F);
		send_data(8'hC3);
		// length with the top bit set, abandoned after two bytes
		send_start(32'h0F0F_0F0F, 8'hF0, 13'd4096, 1'b0);
		send_data(8'h55);
		send_data(8'hAA);
		// empty single packet message
		send_start(32'h0000_0001, 8'h90, 13'd0, 1'b1);

		// saturated length in single packet mode, run to the truncation point
		run_message(13'($urandom_range(MAX_LEN + 1, 8191)), 1'b1, INIT_DATA, 2);

		// random messages, mostly well formed
		goal = useful_reqs + RANDOM_REQS;
		while (useful_reqs < goal) begin
			kind = $urandom_range(0, 99);
			r = $urandom_range(0, 99);
			if (r < 45)
				len = 13'($urandom_range(0, 8));
			else if (r < 70)
				len = 13'($urandom_range(9, 70));
			else if (r < 82)
				len = 13'($urandom_range(71, 180));
			else if (r < 92) begin
				// lengths that end right on a packet boundary or just past it
				case ($urandom_range(0, 3))
					0: len = 13'd57;
					1: len = 13'd58;
					2: len = 13'd116;
					default: len = 13'd117;
				endcase
			end else
				len = 13'($urandom_range(0, 8191));
			sp = ($urandom_range(0, 3) == 0);
			eff = (len > MAX_LEN) ? MAX_LEN : len;
			if (sp && eff > INIT_DATA)
				eff = INIT_DATA;
			if (kind < 75 && eff <= 200) begin
				run_message(len, sp, eff, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
			end else if (kind < 92) begin
				// broken message: stops short, the next start abandons it
				nbytes = (eff == 0) ? 0 : $urandom_range(0, (eff - 1 < 60) ? eff - 1 : 60);
				run_message(len, sp, nbytes, 0);
			end else begin
				repeat ($urandom_range(1, 4)) send_data(8'($urandom));
			end
		end

		// last part, no idling: a message over three packets, then a stray byte
		idle_on = 0;
		run_message(13'd118, 1'b0, 118, 1);
		in_valid <= 1'b0;

		// drain, then let any stray output show itself
		while (stream.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d requests (%0d starts, %0d with output) in %0d cycles",
			reqs_taken, starts_taken, useful_reqs, cycle_count);
		$display("checked %0d stream bytes over %0d packets, %0d mismatches",
			stream.bytes_checked, stream.packets_checked, stream.mismatches);
		if (stream.mismatches == 0 && stream.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
